FILE: rtl/core/pil_pkg.sv
// Shared constants, codes and types for the positional insert/delete list.
`timescale 1ns / 1ps
package pil_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;
  localparam int DATA_W   = 32;
  localparam int GRP_SIZE = 8;
  localparam int NGRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef struct packed {
    logic              go;
    logic              do_ins;
    logic              do_del;
    logic              rd;
    logic [IDX_W-1:0]  slot;
    logic [DATA_W-1:0] data;
  } cell_ctl_t;

endpackage

FILE: rtl/core/pil_cell.sv
// One list slot: holds an entry, shifts with its neighbors, taps out on a read hit.
`timescale 1ns / 1ps
module pil_cell (
  input  logic                      clk,
  input  pil_pkg::cell_ctl_t        ctl,
  input  logic [pil_pkg::IDX_W-1:0] idx,
  input  logic [pil_pkg::DATA_W-1:0] prev,
  input  logic [pil_pkg::DATA_W-1:0] next,
  output logic [pil_pkg::DATA_W-1:0] entry,
  output logic [pil_pkg::DATA_W-1:0] sel
);

  logic hit;
  logic above;

  assign hit   = (idx == ctl.slot);
  assign above = (idx > ctl.slot);

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      sel <= (ctl.rd && hit) ? entry : '0;
      if (ctl.do_ins) begin
        if (hit) begin
          entry <= ctl.data;
        end else if (above) begin
          entry <= prev;
        end
      end else if (ctl.do_del) begin
        if (hit || above) begin
          entry <= next;
        end
      end
    end
  end

endmodule

FILE: rtl/core/positional_insert_delete_list.sv
// Top level of the positional insert/delete list.
// An ordered list of up to CAPACITY signed 32-bit values held in a row of cells. Each input beat
// inserts, deletes or reads at a 1-based position; every beat yields one result beat with status,
// the value read or removed (zero otherwise) and the length after the operation. On acceptance
// all cells shift in parallel and register the tapped addressed entry; a registered OR tree then
// gathers the tapped value, through the group registers into the output register. One beat is
// in flight at a time, so a new beat is taken only once the last one has left the group stage;
// a finished result waits in the output register while the next beat is already accepted.
`timescale 1ns / 1ps
module positional_insert_delete_list (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  operation,
  input  logic [pil_pkg::POS_W-1:0]   position,
  input  logic signed [31:0]          value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic signed [31:0]          value_out,
  output logic [6:0]                  count
);

  logic                        in_go;
  logic [pil_pkg::CNT_W-1:0]   len;
  logic [pil_pkg::CNT_W-1:0]   len_next;
  logic [pil_pkg::CMP_W-1:0]   pos_c;
  logic [pil_pkg::CMP_W-1:0]   len_c;
  pil_pkg::status_t            st_next;
  pil_pkg::cell_ctl_t          ctl;

  logic [pil_pkg::DATA_W-1:0]  entry [pil_pkg::CAPACITY];
  logic [pil_pkg::DATA_W-1:0]  sel   [pil_pkg::CAPACITY];
  logic [pil_pkg::DATA_W-1:0]  grp   [pil_pkg::NGRP];
  logic [pil_pkg::DATA_W-1:0]  grp_next [pil_pkg::NGRP];
  logic [pil_pkg::DATA_W-1:0]  fin_next;

  logic                        s1_v;
  logic                        s2_v;
  pil_pkg::status_t            s1_st;
  pil_pkg::status_t            s2_st;
  logic [pil_pkg::CNT_W-1:0]   s1_cnt;
  logic [pil_pkg::CNT_W-1:0]   s2_cnt;
  logic                        s2_go;

  assign in_stall = s1_v | s2_v;
  assign in_go    = in_valid & ~in_stall;
  assign s2_go    = s2_v & (~out_valid | ~out_stall);

  // decode against the current length
  always_comb begin
    pos_c    = pil_pkg::CMP_W'(position);
    len_c    = pil_pkg::CMP_W'(len);
    st_next  = pil_pkg::ST_OK;
    len_next = len;
    ctl      = '0;
    ctl.go   = in_go;
    ctl.data = value;
    ctl.slot = pil_pkg::IDX_W'(pos_c - pil_pkg::CMP_W'(1));
    unique case (operation)
      pil_pkg::OP_INSERT: begin
        if (pos_c == '0 || pos_c > len_c + pil_pkg::CMP_W'(1)) begin
          st_next = pil_pkg::ST_BADPOS;
        end else if (len_c >= pil_pkg::CMP_W'(pil_pkg::CAPACITY)) begin
          st_next = pil_pkg::ST_FULL;
        end else begin
          ctl.do_ins = 1'b1;
          len_next   = len + pil_pkg::CNT_W'(1);
        end
      end
      pil_pkg::OP_DELETE: begin
        if (pos_c == '0 || pos_c > len_c) begin
          st_next = pil_pkg::ST_BADPOS;
        end else begin
          ctl.do_del = 1'b1;
          ctl.rd     = 1'b1;
          len_next   = len - pil_pkg::CNT_W'(1);
        end
      end
      pil_pkg::OP_READ: begin
        if (pos_c == '0 || pos_c > len_c) begin
          st_next = pil_pkg::ST_BADPOS;
        end else begin
          ctl.rd = 1'b1;
        end
      end
      default: begin
        st_next = pil_pkg::ST_BADPOS;
      end
    endcase
  end

  for (genvar i = 0; i < pil_pkg::CAPACITY; i++) begin : g_cell
    logic [pil_pkg::DATA_W-1:0] prev_d;
    logic [pil_pkg::DATA_W-1:0] next_d;
    if (i == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_mid
      assign prev_d = entry[i-1];
    end
    if (i == pil_pkg::CAPACITY - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_inner
      assign next_d = entry[i+1];
    end
    pil_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .idx   (pil_pkg::IDX_W'(i)),
      .prev  (prev_d),
      .next  (next_d),
      .entry (entry[i]),
      .sel   (sel[i])
    );
  end

  // two-level OR gather of the tapped entry
  always_comb begin
    for (int g = 0; g < pil_pkg::NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < pil_pkg::GRP_SIZE; k++) begin
        if (g * pil_pkg::GRP_SIZE + k < pil_pkg::CAPACITY) begin
          grp_next[g] = grp_next[g] | sel[g * pil_pkg::GRP_SIZE + k];
        end
      end
    end
    fin_next = '0;
    for (int g = 0; g < pil_pkg::NGRP; g++) begin
      fin_next = fin_next | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_go) begin
        len <= len_next;
      end
      s1_v <= in_go;
      if (s1_v) begin
        s2_v <= 1'b1;
      end else if (s2_go) begin
        s2_v <= 1'b0;
      end
      if (s2_go) begin
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_st  <= st_next;
      s1_cnt <= len_next;
    end
    if (s1_v) begin
      s2_st  <= s1_st;
      s2_cnt <= s1_cnt;
      for (int g = 0; g < pil_pkg::NGRP; g++) begin
        grp[g] <= grp_next[g];
      end
    end
    if (s2_go) begin
      status    <= s2_st;
      value_out <= fin_next;
      count     <= 7'(s2_cnt);
    end
  end

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    len <= pil_pkg::CNT_W'(pil_pkg::CAPACITY))
    else $error("list length beyond capacity");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0({s1_v, s2_v}))
    else $error("more than one beat in flight");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_go |=> s1_v)
    else $error("accepted beat did not enter the cells");

  a_gather_moves: assert property (@(posedge clk) disable iff (rst)
    s1_v |=> s2_v && !s1_v)
    else $error("gather stage lost a beat");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != pil_pkg::ST_OK) |-> value_out == '0)
    else $error("nonzero value on failed operation");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the positional insert/delete list.
`timescale 1ns / 1ps
module tb;

  localparam logic [1:0] OP_UNDEF    = 2'd3;
  localparam int         HOLD_CYCLES = 120;
  localparam int         MAX_PRINTED = 40;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] value_out;
    logic [6:0]         count;
  } list_result_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                operation;
  logic [pil_pkg::POS_W-1:0] position;
  logic signed [31:0]        value;
  logic                      out_valid;
  logic                      out_stall;
  logic [1:0]                status;
  logic signed [31:0]        value_out;
  logic [6:0]                count;

  logic signed [31:0] list_entries[$];
  list_result_t       pending_results[$];
  int                 mismatch_count = 0;
  bit                 tx_idle_on = 1'b1;
  bit                 rx_idle_on = 1'b1;
  bit                 hold_off_req = 1'b0;

  positional_insert_delete_list dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .value_out (value_out),
    .count     (count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL positional_insert_delete_list");
    $finish;
  end

  // Expected outcome of one list operation; updates the shadow list.
  function automatic list_result_t apply_list_op(logic [1:0] op,
                                                 logic [pil_pkg::POS_W-1:0] pos,
                                                 logic signed [31:0] val);
    list_result_t r;
    int           len;
    int           p;
    len         = list_entries.size();
    p           = int'(pos);
    r.status    = pil_pkg::ST_OK;
    r.value_out = '0;
    case (op)
      pil_pkg::OP_INSERT: begin
        if (p < 1 || p > len + 1) r.status = pil_pkg::ST_BADPOS;
        else if (len >= pil_pkg::CAPACITY) r.status = pil_pkg::ST_FULL;
        else list_entries.insert(p - 1, val);
      end
      pil_pkg::OP_DELETE: begin
        if (p < 1 || p > len) r.status = pil_pkg::ST_BADPOS;
        else begin
          r.value_out = list_entries[p - 1];
          list_entries.delete(p - 1);
        end
      end
      pil_pkg::OP_READ: begin
        if (p < 1 || p > len) r.status = pil_pkg::ST_BADPOS;
        else r.value_out = list_entries[p - 1];
      end
      default: r.status = pil_pkg::ST_BADPOS;
    endcase
    r.count = 7'(list_entries.size());
    return r;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      3:       return 32'shFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  // Leaves in_valid high on return so back-to-back beats keep it asserted.
  task automatic send_beat(logic [1:0] op, logic [pil_pkg::POS_W-1:0] pos,
                           logic signed [31:0] val);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operation <= op;
    position  <= pos;
    value     <= val;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_list_op(op, pos, val));
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic random_op(int ins_pct, int del_pct, int rd_pct);
    int                        len;
    int                        r;
    logic [1:0]                op;
    logic [pil_pkg::POS_W-1:0] pos;
    len = list_entries.size();
    r   = $urandom_range(0, 99);
    pos = pil_pkg::POS_W'($urandom_range(0, 127));
    if (r < ins_pct) begin
      op = pil_pkg::OP_INSERT;
      if ($urandom_range(0, 9) != 0) pos = pil_pkg::POS_W'($urandom_range(1, len + 1));
    end else if (r < ins_pct + del_pct) begin
      op = pil_pkg::OP_DELETE;
      if ($urandom_range(0, 9) != 0 && len > 0)
        pos = pil_pkg::POS_W'($urandom_range(1, len));
    end else if (r < ins_pct + del_pct + rd_pct) begin
      op = pil_pkg::OP_READ;
      if ($urandom_range(0, 9) != 0 && len > 0)
        pos = pil_pkg::POS_W'($urandom_range(1, len));
    end else begin
      op = 2'($urandom_range(0, 3));
    end
    send_beat(op, pos, pick_value());
  endtask

  task automatic test_directed();
    send_beat(pil_pkg::OP_READ,   7'd1,   32'sd5);
    send_beat(pil_pkg::OP_DELETE, 7'd1,   32'sd5);
    send_beat(pil_pkg::OP_INSERT, 7'd0,   32'sd9);
    send_beat(pil_pkg::OP_INSERT, 7'd2,   32'sd9);
    send_beat(pil_pkg::OP_INSERT, 7'd1,   32'sh7FFF_FFFF);
    send_beat(pil_pkg::OP_INSERT, 7'd1,   32'sh8000_0000);
    send_beat(pil_pkg::OP_INSERT, 7'd3,   32'shFFFF_FFFF);
    send_beat(pil_pkg::OP_INSERT, 7'd2,   32'sd0);
    send_beat(pil_pkg::OP_READ,   7'd4,   32'sd0);
    send_beat(pil_pkg::OP_READ,   7'd1,   32'sd0);
    send_beat(pil_pkg::OP_READ,   7'd5,   32'sd0);
    send_beat(pil_pkg::OP_READ,   7'd127, 32'sd0);
    send_beat(pil_pkg::OP_DELETE, 7'd5,   32'sd0);
    send_beat(pil_pkg::OP_DELETE, 7'd0,   32'sd0);
    send_beat(OP_UNDEF,           7'd1,   32'sh5A5A_A5A5);
    send_beat(pil_pkg::OP_DELETE, 7'd2,   32'sd0);
    send_beat(pil_pkg::OP_DELETE, 7'd3,   32'sd0);
    send_beat(pil_pkg::OP_READ,   7'd0,   32'sd0);
    send_beat(pil_pkg::OP_INSERT, 7'd4,   32'sd77);
    send_beat(pil_pkg::OP_INSERT, 7'd127, 32'sd77);
  endtask

  task automatic test_fill_and_full();
    while (list_entries.size() < pil_pkg::CAPACITY)
      send_beat(pil_pkg::OP_INSERT,
                pil_pkg::POS_W'($urandom_range(1, list_entries.size() + 1)), pick_value());
    send_beat(pil_pkg::OP_INSERT, 7'(pil_pkg::CAPACITY + 1), pick_value());
    send_beat(pil_pkg::OP_INSERT, 7'd1,                      pick_value());
    send_beat(pil_pkg::OP_INSERT, 7'd0,                      pick_value());
    send_beat(pil_pkg::OP_INSERT, 7'(pil_pkg::CAPACITY + 2), pick_value());
    send_beat(pil_pkg::OP_INSERT, 7'd127,                    pick_value());
    send_beat(pil_pkg::OP_READ,   7'(pil_pkg::CAPACITY),     pick_value());
    send_beat(pil_pkg::OP_READ,   7'(pil_pkg::CAPACITY + 1), pick_value());
    send_beat(pil_pkg::OP_DELETE, 7'(pil_pkg::CAPACITY + 1), pick_value());
    send_beat(pil_pkg::OP_DELETE, 7'(pil_pkg::CAPACITY),     pick_value());
    while (list_entries.size() > 0) begin
      if ($urandom_range(0, 3) == 0)
        send_beat(pil_pkg::OP_READ,
                  pil_pkg::POS_W'($urandom_range(1, list_entries.size())), pick_value());
      send_beat(pil_pkg::OP_DELETE,
                pil_pkg::POS_W'($urandom_range(1, list_entries.size())), pick_value());
    end
  endtask

  task automatic test_random_mix(int n);
    repeat (n) random_op(40, 30, 25);
  endtask

  // Receiver holds off while beats keep coming so the input side backs up.
  task automatic test_backpressure();
    bit saved;
    saved        = tx_idle_on;
    tx_idle_on   = 1'b0;
    hold_off_req = 1'b1;
    repeat (30) random_op(45, 30, 20);
    tx_idle_on   = saved;
  endtask

  task automatic test_sender_pause_then_burst();
    wait_all_results();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (150) random_op(40, 30, 25);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    out_stall = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall    <= 1'b0;
        hold_off_req = 1'b0;
        @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (idle_len()) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", value_out, '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (value_out !== want.value_out)
          report_mismatch("value_out", value_out, want.value_out);
        if (count !== want.count)
          report_mismatch("count", 32'(count), 32'(want.count));
      end
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    operation = '0;
    position  = '0;
    value     = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_and_full();
    test_random_mix(600);
    test_backpressure();
    test_sender_pause_then_burst();
    test_random_mix(200);

    wait_all_results();
    rx_idle_on = 1'b0;
    repeat (12) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASS positional_insert_delete_list");
    else
      $display("FAIL positional_insert_delete_list");
    $finish;
  end

endmodule
